// ----- hw/rtl/tcpq_pkg.sv -----
// ----------------------------------------------------------------------------
// tcpq_pkg
// shared types and constants of the three class priority queue
// ----------------------------------------------------------------------------
package tcpq_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF = 16;
    localparam int CLS_W       = 2;
    localparam int NUM_CLS     = 3;

    typedef logic [CLS_W-1:0] cls_t;

    localparam cls_t VIP     = 2'd0;
    localparam cls_t MIDDLE  = 2'd1;
    localparam cls_t GENERAL = 2'd2;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // request from the controller to the pointer logic
    typedef struct packed {
        logic enq;
        logic deq;
        cls_t enq_cls;
    } sched_ctrl_t;

    // queue condition back to the controller
    typedef struct packed {
        logic empty;
        logic full;
        cls_t head_cls;
    } sched_stat_t;

endpackage

// ----- hw/rtl/tcpq_mem.sv -----
// ----------------------------------------------------------------------------
// tcpq_mem
// entry id storage, one write port, one registered read port
// ----------------------------------------------------------------------------
module tcpq_mem #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 16,
    parameter int WORDS  = 48
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [WORDS];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/tcpq_sched.sv -----
// ----------------------------------------------------------------------------
// tcpq_sched
// per class ring pointers and counts; picks the head class
// ----------------------------------------------------------------------------
module tcpq_sched #(
    parameter int DEPTH = 16,
    parameter int PTR_W = 4,
    parameter int CNT_W = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tcpq_pkg::sched_ctrl_t  ctrl,
    output tcpq_pkg::sched_stat_t  stat,
    output logic [PTR_W+1:0]       wr_addr,
    output logic [PTR_W+1:0]       rd_addr,
    output logic [CNT_W-1:0]       held
);

    import tcpq_pkg::*;

    logic [PTR_W-1:0] head_reg [NUM_CLS];
    logic [PTR_W-1:0] head_next [NUM_CLS];
    logic [PTR_W-1:0] tail_reg [NUM_CLS];
    logic [PTR_W-1:0] tail_next [NUM_CLS];
    logic [CNT_W-1:0] cnt_reg [NUM_CLS];
    logic [CNT_W-1:0] cnt_next [NUM_CLS];
    logic [CNT_W-1:0] held_reg;
    logic [CNT_W-1:0] held_next;
    cls_t             head_cls;
    logic [PTR_W-1:0] head_sel;
    logic [PTR_W-1:0] tail_sel;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        if (cnt_reg[0] != '0)
        begin
            head_cls = VIP;
        end
        else if (cnt_reg[1] != '0)
        begin
            head_cls = MIDDLE;
        end
        else
        begin
            head_cls = GENERAL;
        end
    end

    // small muxes over the three classes
    always_comb
    begin
        head_sel = head_reg[0];
        tail_sel = tail_reg[0];
        for (int c = 1; c < NUM_CLS; c++)
        begin
            if (head_cls == cls_t'(c))
            begin
                head_sel = head_reg[c];
            end
            if (ctrl.enq_cls == cls_t'(c))
            begin
                tail_sel = tail_reg[c];
            end
        end
    end

    assign rd_addr = {head_cls, head_sel};
    assign wr_addr = {ctrl.enq_cls, tail_sel};

    always_comb
    begin
        held_next = held_reg;
        for (int c = 0; c < NUM_CLS; c++)
        begin
            head_next[c] = head_reg[c];
            tail_next[c] = tail_reg[c];
            cnt_next[c]  = cnt_reg[c];
            if (ctrl.enq && ctrl.enq_cls == cls_t'(c))
            begin
                tail_next[c] = ptr_inc(tail_reg[c]);
                cnt_next[c]  = cnt_reg[c] + 1'b1;
            end
            if (ctrl.deq && head_cls == cls_t'(c))
            begin
                head_next[c] = ptr_inc(head_reg[c]);
                cnt_next[c]  = cnt_reg[c] - 1'b1;
            end
        end
        if (ctrl.enq)
        begin
            held_next = held_reg + 1'b1;
        end
        else if (ctrl.deq)
        begin
            held_next = held_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            for (int c = 0; c < NUM_CLS; c++)
            begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                cnt_reg[c]  <= '0;
            end
        end
        else
        begin
            held_reg <= held_next;
            for (int c = 0; c < NUM_CLS; c++)
            begin
                head_reg[c] <= head_next[c];
                tail_reg[c] <= tail_next[c];
                cnt_reg[c]  <= cnt_next[c];
            end
        end
    end

    assign stat.empty    = (held_reg == '0);
    assign stat.full     = (held_reg == CNT_W'(DEPTH));
    assign stat.head_cls = head_cls;
    assign held          = held_reg;

endmodule

// ----- hw/rtl/three_class_priority_queue.sv -----
// ----------------------------------------------------------------------------
// three_class_priority_queue
// bounded queue of ids ordered by class (0 first), fifo within a class
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries action, entry_id, entry_class.
// action 0 enqueues entry_id in class entry_class (class 3 counts as 2);
// action 1 dequeues the head, the oldest entry of the best class held.
// Each input beat yields exactly one result beat on out_valid/out_ready:
// status, served_id, served_class and occupancy after the item.
// Enqueue and failed dequeue results are registered in the cycle after the
// input beat; a served dequeue first passes S_DEQ, reading the id memory.
// One enqueue per cycle while out_ready is high; no beat is taken in
// S_DEQ. The next input beat is taken in the cycle the result register
// frees up, so a waiting result does not block it while out_ready is high.
// Ids live in one memory split into a ring per class; pointers and counts
// live in flip-flops. Reset empties the queue at once (no clearing pass);
// memory contents are left as they are. When the receiver stalls, the
// result holds and no further input beat is accepted.
// ----------------------------------------------------------------------------
module three_class_priority_queue #(
    parameter int DEPTH   = tcpq_pkg::DEPTH_DEF,
    parameter int ID_BITS = tcpq_pkg::ID_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       action,
    input  logic [ID_BITS-1:0]         entry_id,
    input  logic [tcpq_pkg::CLS_W-1:0] entry_class,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output logic [ID_BITS-1:0]         served_id,
    output logic [tcpq_pkg::CLS_W-1:0] served_class,
    output logic [$clog2(DEPTH+1)-1:0] occupancy
);

    import tcpq_pkg::*;

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = PTR_W + CLS_W;
    localparam int WORDS  = NUM_CLS * (1 << PTR_W);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DEQ  = 2'b10
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    status_t             status_reg;
    status_t             status_next;
    logic [ID_BITS-1:0]  id_reg;
    logic [ID_BITS-1:0]  id_next;
    cls_t                cls_reg;
    cls_t                cls_next;
    logic [CNT_W-1:0]    occ_reg;
    logic [CNT_W-1:0]    occ_next;
    cls_t                deq_cls_reg;
    cls_t                deq_cls_next;

    logic                acc;
    logic                out_free;
    cls_t                enq_cls;
    sched_ctrl_t         ctrl;
    sched_stat_t         stat;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic [CNT_W-1:0]    held;
    logic [ID_BITS-1:0]  rd_data;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign acc      = in_valid && in_ready;
    assign enq_cls  = (entry_class > GENERAL) ? GENERAL : entry_class;

    assign ctrl.enq     = acc && (action == ACT_ENQ) && !stat.full;
    assign ctrl.deq     = acc && (action == ACT_DEQ) && !stat.empty;
    assign ctrl.enq_cls = enq_cls;

    tcpq_sched #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W),
        .CNT_W (CNT_W)
    ) u_sched (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .stat    (stat),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .held    (held)
    );

    tcpq_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (ID_BITS),
        .WORDS  (WORDS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (ctrl.enq),
        .wr_addr (wr_addr),
        .wr_data (entry_id),
        .rd_en   (ctrl.deq),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        id_next        = id_reg;
        cls_next       = cls_reg;
        occ_next       = occ_reg;
        deq_cls_next   = deq_cls_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (ctrl.deq)
                    begin
                        deq_cls_next = stat.head_cls;
                        state_next   = S_DEQ;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        id_next        = '0;
                        cls_next       = VIP;
                        occ_next       = held;
                        if (ctrl.enq)
                        begin
                            status_next = ST_OK;
                            occ_next    = held + 1'b1;
                        end
                        else if (action == ACT_ENQ)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            status_next = ST_EMPTY;
                        end
                    end
                end
            end
            S_DEQ:
            begin
                // read data is held until the result slot frees
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    id_next        = rd_data;
                    cls_next       = deq_cls_reg;
                    occ_next       = held;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        id_reg      <= id_next;
        cls_reg     <= cls_next;
        occ_reg     <= occ_next;
        deq_cls_reg <= deq_cls_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign served_id    = id_reg;
    assign served_class = cls_reg;
    assign occupancy    = occ_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (occupancy <= CNT_W'(DEPTH)))
        else $error("occupancy above depth");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_reg != ST_OK) |-> (served_id == '0 && served_class == VIP))
        else $error("failed beat carries served data");

    a_deq_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.deq |=> (state_reg == S_DEQ && held == $past(held) - 1'b1))
        else $error("dequeue did not start a memory read");

    a_enq_ok: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.enq |=> (out_valid && status_reg == ST_OK && occupancy == held))
        else $error("enqueue result mismatch");

endmodule

// ----- verif/tb_three_class_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_class_priority_queue
// self-checking bench for the three class priority queue
// ----------------------------------------------------------------------------
// A short list of directed beats covers the extremes first: an empty dequeue,
// class three folding into general, filling to the brim, a dropped enqueue
// and ordering within a class. Random phases with different enqueue mixes
// follow. A queue model predicts each result a row does not give; the monitor
// compares them field by field. Both sides idle at random. In one phase the
// receiver holds off for a long stretch so that the block stalls its input.
// ----------------------------------------------------------------------------
module tb_three_class_priority_queue;
    import tcpq_pkg::*;

    localparam int QDEPTH      = DEPTH_DEF;
    localparam int IDW         = ID_BITS_DEF;
    localparam int OCCW        = $clog2(QDEPTH + 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 120;
    localparam int RAND_PHASES = 5;
    localparam int PHASE_ITEMS = 100;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        status_t         st;
        logic [IDW-1:0]  id;
        cls_t            cls;
        logic [OCCW-1:0] occ;
    } result_t;

    typedef struct packed {
        logic [IDW-1:0] id;
        cls_t           cls;
    } entry_t;

    typedef struct packed {
        logic           act;
        logic [IDW-1:0] id;
        cls_t           cls;
        logic           typed;
        result_t        res;
    } row_t;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            in_valid;
    logic            in_ready;
    logic            action;
    logic [IDW-1:0]  entry_id;
    cls_t            entry_class;
    logic            out_valid;
    logic            out_ready = 1'b0;
    logic [1:0]      status;
    logic [IDW-1:0]  served_id;
    cls_t            served_class;
    logic [OCCW-1:0] occupancy;

    entry_t  held[$];
    result_t awaited[$];
    row_t    directed_rows[$];

    int  errors       = 0;
    int  checked      = 0;
    int  items_sent   = 0;
    int  full_drops   = 0;
    int  empty_deqs   = 0;
    int  peak_occ     = 0;
    int  cycles       = 0;
    int  hold_reqs    = 0;
    int  holds_done   = 0;
    int  stall_left   = 0;
    bit  idle_en      = 1'b1;

    three_class_priority_queue #(
        .DEPTH   (QDEPTH),
        .ID_BITS (IDW)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .entry_id     (entry_id),
        .entry_class  (entry_class),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .served_id    (served_id),
        .served_class (served_class),
        .occupancy    (occupancy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, awaited.size());
            $display("simulation failed");
            $finish;
        end
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_en || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // sorted insert behind every entry of the same or a better class
    function automatic result_t queue_outcome(logic act, logic [IDW-1:0] id, cls_t cls);
        result_t r;
        entry_t  e;
        int      pos;
        r = '0;
        r.st = ST_OK;
        if (act == ACT_ENQ)
        begin
            if (cls > GENERAL)
                cls = GENERAL;
            if (held.size() >= QDEPTH)
            begin
                r.st = ST_FULL;
                full_drops++;
            end
            else
            begin
                pos = 0;
                while (pos < held.size() && held[pos].cls <= cls)
                    pos++;
                e.id = id;
                e.cls = cls;
                held.insert(pos, e);
            end
        end
        else if (held.size() == 0)
        begin
            r.st = ST_EMPTY;
            empty_deqs++;
        end
        else
        begin
            e = held.pop_front();
            r.id = e.id;
            r.cls = e.cls;
        end
        r.occ = OCCW'(held.size());
        if (held.size() > peak_occ)
            peak_occ = held.size();
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h got %0h", $realtime, what, want, got);
    endtask

    // result side: compare each beat against the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result beat with nothing awaited (status %0h id %0h)",
                             $realtime, status, served_id);
            end
            else
            begin
                want = awaited.pop_front();
                checked++;
                if (status !== 2'(want.st))
                    report_mismatch("status", want.st, status);
                if (served_id !== want.id)
                    report_mismatch("served_id", want.id, served_id);
                if (served_class !== want.cls)
                    report_mismatch("served_class", want.cls, served_class);
                if (occupancy !== want.occ)
                    report_mismatch("occupancy", want.occ, occupancy);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin : receiver
        int s;
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (holds_done != hold_reqs)
            begin
                out_ready <= 1'b0;
                stall_left <= HOLD_CYCLES - 1;
                holds_done <= holds_done + 1;
            end
            else
            begin
                s = gap_len();
                out_ready <= (s == 0);
                stall_left <= (s > 0) ? s - 1 : 0;
            end
        end
    end

    task automatic push_item(input logic act, input logic [IDW-1:0] id, input cls_t cls,
                             input logic typed, input result_t typed_res);
        result_t r;
        int      gap;
        in_valid <= 1'b1;
        action <= act;
        entry_id <= id;
        entry_class <= cls;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = queue_outcome(act, id, cls);
        awaited.push_back(typed ? typed_res : r);
        items_sent++;
        gap = gap_len();
        if (gap > 0)
        begin
            // junk payload while idle
            in_valid <= 1'b0;
            action <= $urandom_range(0, 1);
            entry_id <= IDW'($urandom);
            entry_class <= cls_t'($urandom_range(0, 3));
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited.size() != 0);
    endtask

    task automatic rand_item(int enq_pct);
        logic           act;
        logic [IDW-1:0] id;
        int             r;
        act = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
        r = $urandom_range(0, 99);
        if (r < 4)
            id = '1;
        else if (r < 8)
            id = '0;
        else
            id = IDW'($urandom);
        push_item(act, id, cls_t'($urandom_range(0, 3)), 1'b0, '0);
    endtask

    task automatic add_row(logic act, logic [IDW-1:0] id, cls_t cls, logic typed,
                           status_t st, logic [IDW-1:0] sid, cls_t scls, int occ);
        row_t r;
        r.act = act;
        r.id = id;
        r.cls = cls;
        r.typed = typed;
        r.res.st = st;
        r.res.id = sid;
        r.res.cls = scls;
        r.res.occ = OCCW'(occ);
        directed_rows.push_back(r);
    endtask

    initial
    begin : stimulus
        int enq_mix[RAND_PHASES];
        int p;
        int i;
        enq_mix = '{55, 85, 20, 50, 65};

        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_ENQ;
        entry_id = '0;
        entry_class = VIP;

        // empty dequeue, then class three folds into general
        add_row(ACT_DEQ, 16'h0000, VIP, 1'b1, ST_EMPTY, '0, VIP, 0);
        add_row(ACT_ENQ, 16'hFFFF, GENERAL, 1'b1, ST_OK, '0, VIP, 1);
        add_row(ACT_ENQ, 16'h0000, VIP, 1'b1, ST_OK, '0, VIP, 2);
        add_row(ACT_ENQ, 16'h1234, cls_t'(2'b11), 1'b1, ST_OK, '0, VIP, 3);
        add_row(ACT_ENQ, 16'hA5A5, MIDDLE, 1'b1, ST_OK, '0, VIP, 4);
        add_row(ACT_ENQ, 16'h5A5A, VIP, 1'b1, ST_OK, '0, VIP, 5);
        for (i = 0; i < QDEPTH - 5; i++)
            add_row(ACT_ENQ, IDW'(16'h0100 + i), cls_t'(i % NUM_CLS), 1'b1,
                    ST_OK, '0, VIP, 6 + i);
        // full queue drops the beat
        add_row(ACT_ENQ, 16'hBEEF, VIP, 1'b1, ST_FULL, '0, VIP, QDEPTH);
        add_row(ACT_DEQ, 16'hFFFF, GENERAL, 1'b1, ST_OK, 16'h0000, VIP, QDEPTH - 1);
        for (i = 0; i < 6; i++)
            add_row(ACT_DEQ, IDW'($urandom), cls_t'($urandom_range(0, 3)), 1'b0,
                    ST_OK, '0, VIP, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            push_item(directed_rows[k].act, directed_rows[k].id, directed_rows[k].cls,
                      directed_rows[k].typed, directed_rows[k].res);

        for (p = 0; p < RAND_PHASES; p++)
        begin
            wait_drained();
            // phase 3 runs back to back on both sides
            idle_en <= (p != 3);
            if (p == 1)
                hold_reqs <= hold_reqs + 1;
            for (i = 0; i < PHASE_ITEMS; i++)
                rand_item(enq_mix[p]);
        end

        wait_drained();
        repeat (10) @(posedge clk);

        $display("%0d beats sent, %0d results checked, peak occupancy %0d",
                 items_sent, checked, peak_occ);
        $display("%0d enqueues dropped as full, %0d dequeues found empty, %0d errors",
                 full_drops, empty_deqs, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
